@@ hw/rtl/lcss_pkg.sv @@
package lcss_pkg;

  // Event codes carried on the input tuser
  localparam logic [1:0] CMD_RISE  = 2'd0;
  localparam logic [1:0] CMD_FALL  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register select, taken from paddr bit 2 (registers at byte 0 and 4)
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_FILL    = 1'b1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd200;
  localparam logic [7:0]  FILL_RESET    = 8'd0;
  localparam logic [2:0]  LAST_BIT      = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        sin;
    logic [31:0] ts;
    logic [7:0]  wbyte;
  } lcss_item_t;

  typedef struct packed {
    logic [31:0] timeout_us;
    logic [7:0]  fill_byte;
  } lcss_cfg_t;

  typedef struct packed {
    logic       serial_out_bit;
    logic       byte_done;
    logic [7:0] rx_byte;
  } lcss_result_t;

endpackage

@@ hw/rtl/lcss_engine.sv @@
module lcss_engine
  import lcss_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  lcss_item_t   item,
  input  lcss_cfg_t    cfg,
  output lcss_result_t res
);

  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic [2:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  tx_shift_r, tx_shift_nxt;
  logic [7:0]  pending_byte_r, pending_byte_nxt;
  logic        pending_valid_r, pending_valid_nxt;
  logic [31:0] last_edge_r, last_edge_nxt;
  logic        out_level_r, out_level_nxt;

  logic [31:0] elapsed;
  logic        timed_out;
  logic [7:0]  rx_base;
  logic [2:0]  cnt_base;
  logic [7:0]  rx_next;

  // Wrapping gap since the previous rising edge; a stale partial byte is dropped
  assign elapsed   = item.ts - last_edge_r;
  assign timed_out = elapsed > cfg.timeout_us;
  assign rx_base   = timed_out ? 8'd0 : rx_shift_r;
  assign cnt_base  = timed_out ? 3'd0 : bit_count_r;
  assign rx_next   = {rx_base[6:0], item.sin};

  always_comb begin
    rx_shift_nxt      = rx_shift_r;
    bit_count_nxt     = bit_count_r;
    tx_shift_nxt      = tx_shift_r;
    pending_byte_nxt  = pending_byte_r;
    pending_valid_nxt = pending_valid_r;
    last_edge_nxt     = last_edge_r;
    out_level_nxt     = out_level_r;
    res.byte_done     = 1'b0;
    res.rx_byte       = 8'd0;
    unique case (item.cmd)
      CMD_RISE: begin
        last_edge_nxt = item.ts;
        rx_shift_nxt  = rx_next;
        if (cnt_base == LAST_BIT) begin
          bit_count_nxt = 3'd0;
          res.byte_done = 1'b1;
          res.rx_byte   = rx_next;
          if (pending_valid_r) begin
            tx_shift_nxt      = pending_byte_r;
            pending_valid_nxt = 1'b0;
          end else begin
            tx_shift_nxt = cfg.fill_byte;
          end
        end else begin
          bit_count_nxt = cnt_base + 3'd1;
        end
      end
      CMD_FALL: begin
        out_level_nxt = tx_shift_r[7];
        tx_shift_nxt  = {tx_shift_r[6:0], 1'b0};
      end
      CMD_WRITE: begin
        if (bit_count_r == 3'd0) begin
          tx_shift_nxt      = item.wbyte;
          pending_valid_nxt = 1'b0;
        end else begin
          pending_byte_nxt  = item.wbyte;
          pending_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.serial_out_bit = out_level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_shift_r      <= 8'd0;
      bit_count_r     <= 3'd0;
      tx_shift_r      <= 8'd0;
      pending_byte_r  <= 8'd0;
      pending_valid_r <= 1'b0;
      last_edge_r     <= 32'd0;
      out_level_r     <= 1'b0;
    end else if (en) begin
      rx_shift_r      <= rx_shift_nxt;
      bit_count_r     <= bit_count_nxt;
      tx_shift_r      <= tx_shift_nxt;
      pending_byte_r  <= pending_byte_nxt;
      pending_valid_r <= pending_valid_nxt;
      last_edge_r     <= last_edge_nxt;
      out_level_r     <= out_level_nxt;
    end
  end

endmodule

@@ hw/rtl/link_cable_serial_slave.sv @@
// Pipeline: an accepted beat is held in the input register; its result is registered in the
// result register once that stage can advance and is offered on out_* from then on.
// Throughput: one beat per cycle while the sink does not stall; the shift/count update and
// the 32-bit gap compare are combinational between the input and result registers.
// Reset: rst_n is synchronous and active low; it empties both stages, clears all shift
// state and restores timeout_us to 200 and fill_byte to 0.
module link_cable_serial_slave
  import lcss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [0] serial_in_bit, [32:1] timestamp_us, [40:33] tx_byte
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] serial_out_bit, [8:1] rx_byte
  output logic        out_tuser,  // [0] byte_done
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers
  lcss_cfg_t cfg_r;
  logic      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_us <= TIMEOUT_RESET;
      cfg_r.fill_byte  <= FILL_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_TIMEOUT: cfg_r.timeout_us <= cfg_pwdata;
        REG_FILL:    cfg_r.fill_byte  <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_TIMEOUT: cfg_prdata = cfg_r.timeout_us;
      REG_FILL:    cfg_prdata = {24'd0, cfg_r.fill_byte};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // Input register: take a beat whenever it is empty or draining this cycle
  logic       in_valid_r;
  lcss_item_t in_item_r;
  logic       advance;
  logic       in_fire;

  // Result register frees up when empty or when the sink takes it
  logic         out_valid_r;
  lcss_result_t out_res_r;
  lcss_result_t res;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; hold it while the stage is stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.cmd   <= in_tuser;
      in_item_r.sin   <= in_tdata[0];
      in_item_r.ts    <= in_tdata[32:1];
      in_item_r.wbyte <= in_tdata[40:33];
    end
  end

  // Shift state advances exactly once per beat, as it moves into the result register
  lcss_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_valid_r && advance),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.rx_byte, out_res_r.serial_out_bit};
  assign out_tuser  = out_res_r.byte_done;

`ifndef NO_ASSERTIONS
  // A completed byte can only come from a rising-edge event
  a_done_from_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && advance && res.byte_done) |-> (in_item_r.cmd == CMD_RISE))
    else $error("byte_done produced by a non-rising event");

  // Received byte reads zero unless a byte completed
  a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.byte_done) |-> (out_res_r.rx_byte == 8'd0))
    else $error("rx_byte nonzero without byte_done");

  // With both stages full and the sink stalled, no beat may enter
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline is full");

  // A stalled result stage keeps its result through the next edge
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result changed");
`endif

endmodule
